// ===== design/lcsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcsm_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxRadius = 8;
  localparam int unsigned FullScale = 255;

  // Pixel store address, coordinate and frame size widths.
  localparam int unsigned AddrW  = 16;
  localparam int unsigned CoordW = 8;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned TotalW = 17;

  // Shared divider: 16-bit dividend, 9-bit divisor, one quotient bit a cycle.
  localparam int unsigned NumW     = 16;
  localparam int unsigned DenW     = 9;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned StepW    = 5;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIX_INIT,
    S_CADDR,
    S_CREAD,
    S_CLATCH,
    S_WALK,
    S_DRAIN,
    S_MDIV,
    S_MWAIT,
    S_STORE,
    S_RDIV,
    S_RWAIT,
    S_EMIT
  } state_e;

  // Clamped frame settings handed from the register file to the core.
  typedef struct packed {
    logic [3:0]        radius;
    logic [SizeW-1:0]  width;
    logic [SizeW-1:0]  height;
    logic [TotalW-1:0] total;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/local_contrast_saliency_map_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Local contrast saliency map. Send a grayscale frame in raster order as
// transactions with tuser (mode) low, one 8-bit pixel each; the block takes
// them at one per cycle while it is idle. The transaction that completes the
// frame (width x height pixels, as configured at that moment) starts the map
// build, during which tready stays low: for every pixel the block fetches the
// center pixel, walks its window of up to 2R x 2R source pixels one read per
// cycle through the single read port of the source memory, and divides the
// sum of absolute differences by the window size on a shared bit-serial
// divider. Afterwards each transaction with tuser high returns one saliency
// value in raster order, scaled so the strongest contrast reads 255, computed
// on the same 16-step divider, with tlast on the final pixel; reading wraps
// to the start of the map. A read before any map exists returns zero. The
// memories are not cleared after reset, and none need be. Configuration
// writes (index 0 radius, 1 width, 2 height) are accepted in every cycle and
// must only happen while the block is idle; out-of-range values are clamped,
// the radius after keeping only the low four bits of the written value.

module local_contrast_saliency_map_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_addr_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  wire logic       s_axis_tuser,   // [0] mode
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] saliency
  output logic            m_axis_tlast    // last_pixel
);

  logic [3:0]                 radius_q;
  logic [lcsm_pkg::SizeW-1:0] width_q, height_q;
  lcsm_pkg::cfg_t             cfg;

  assign cfg_ready_o = 1'b1;

  // Register file; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd5;
      width_q  <= lcsm_pkg::SizeW'(lcsm_pkg::MaxWidth);
      height_q <= lcsm_pkg::SizeW'(lcsm_pkg::MaxHeight);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        lcsm_pkg::CFG_RADIUS: radius_q <= cfg_data_i[3:0];
        lcsm_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        lcsm_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the settings to the supported ranges and form the frame size.
  always_comb begin
    if (radius_q == '0) begin
      cfg.radius = 4'd1;
    end else if (radius_q > 4'(lcsm_pkg::MaxRadius)) begin
      cfg.radius = 4'(lcsm_pkg::MaxRadius);
    end else begin
      cfg.radius = radius_q;
    end
    if (width_q == '0) begin
      cfg.width = lcsm_pkg::SizeW'(1);
    end else if (width_q > lcsm_pkg::SizeW'(lcsm_pkg::MaxWidth)) begin
      cfg.width = lcsm_pkg::SizeW'(lcsm_pkg::MaxWidth);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == '0) begin
      cfg.height = lcsm_pkg::SizeW'(1);
    end else if (height_q > lcsm_pkg::SizeW'(lcsm_pkg::MaxHeight)) begin
      cfg.height = lcsm_pkg::SizeW'(lcsm_pkg::MaxHeight);
    end else begin
      cfg.height = height_q;
    end
    cfg.total = {{(lcsm_pkg::TotalW-lcsm_pkg::SizeW){1'b0}}, cfg.width} *
                {{(lcsm_pkg::TotalW-lcsm_pkg::SizeW){1'b0}}, cfg.height};
  end

  lcsm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== design/lcsm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsm_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lcsm_pkg::NumW-1:0]  num_i,
  input  wire logic [lcsm_pkg::DenW-1:0]  den_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [lcsm_pkg::NumW-1:0]       quot_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [lcsm_pkg::StepW-1:0]    step_q;
  logic [lcsm_pkg::NumW-1:0]     quo_q;
  logic [lcsm_pkg::DenW-1:0]     den_q;
  logic [lcsm_pkg::DenW:0]       rem_q;
  logic [lcsm_pkg::DenW:0]       trial;
  logic                          fits;
  logic [lcsm_pkg::DenW:0]       rem_d;

  // Restoring division: the remainder stays below the divisor.
  always_comb begin
    trial = {rem_q[lcsm_pkg::DenW-1:0], quo_q[lcsm_pkg::NumW-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? (trial - {1'b0, den_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= lcsm_pkg::StepW'(lcsm_pkg::DivSteps);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == lcsm_pkg::StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[lcsm_pkg::NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== design/lcsm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsm_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lcsm_pkg::cfg_t cfg_i,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [7:0]     s_axis_tdata,   // pixel
  input  wire logic           s_axis_tuser,   // mode
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // saliency
  output logic                m_axis_tlast    // last_pixel
);

  localparam int unsigned AW = lcsm_pkg::AddrW;
  localparam int unsigned CW = lcsm_pkg::CoordW;
  localparam int unsigned TW = lcsm_pkg::TotalW;

  lcsm_pkg::state_e state_q, state_d;

  logic [7:0] src_mem [lcsm_pkg::MaxWidth*lcsm_pkg::MaxHeight];
  logic [7:0] con_mem [lcsm_pkg::MaxWidth*lcsm_pkg::MaxHeight];

  logic [AW-1:0] load_pos_q, read_pos_q, pix_q, addr_q;
  logic          map_valid_q;
  logic [TW-1:0] map_total_q;
  logic [7:0]    peak_q;
  logic [CW-1:0] x_q, y_q, x0_q, y0_q, xl_q, yl_q, wx_q, wy_q;
  logic [7:0]    centre_q, data_q, cdata_q, res_q;
  logic [15:0]   sum_q;
  logic [8:0]    cnt_q;
  logic          v0_q, v1_q, last_q;
  logic          m_valid_q, m_last_q;
  logic [7:0]    m_data_q;

  logic                        s_fire, load_trig, read_ok, last_issue, pix_last;
  logic                        issue, div_start, div_busy, div_done;
  logic [lcsm_pkg::NumW-1:0]   div_num, div_quot;
  logic [lcsm_pkg::DenW-1:0]   div_den;
  logic [TW-1:0]               lp_next, rp_next, pix_next, walk_prod;
  logic [CW+1:0]               yend, xend;
  logic [7:0]                  diff;

  always_comb begin
    s_fire     = s_axis_tvalid && s_axis_tready;
    lp_next    = {1'b0, load_pos_q} + TW'(1);
    rp_next    = {1'b0, read_pos_q} + TW'(1);
    pix_next   = {1'b0, pix_q} + TW'(1);
    load_trig  = lp_next >= cfg_i.total;
    read_ok    = map_valid_q && (map_total_q != '0) && ({1'b0, read_pos_q} < map_total_q);
    pix_last   = pix_next == cfg_i.total;
    last_issue = (wy_q == yl_q) && (wx_q == xl_q);
    walk_prod  = {{(TW-CW){1'b0}}, wy_q} * {{(TW-lcsm_pkg::SizeW){1'b0}}, cfg_i.width};
    yend       = {2'b00, y_q} + {{(CW-2){1'b0}}, cfg_i.radius};
    xend       = {2'b00, x_q} + {{(CW-2){1'b0}}, cfg_i.radius};
    diff       = (data_q > centre_q) ? (data_q - centre_q) : (centre_q - data_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcsm_pkg::S_IDLE: begin
        if (s_fire) begin
          if (!s_axis_tuser) begin
            if (load_trig) state_d = lcsm_pkg::S_PIX_INIT;
          end else begin
            state_d = read_ok ? lcsm_pkg::S_RDIV : lcsm_pkg::S_EMIT;
          end
        end
      end
      lcsm_pkg::S_PIX_INIT: state_d = lcsm_pkg::S_CADDR;
      lcsm_pkg::S_CADDR:    state_d = lcsm_pkg::S_CREAD;
      lcsm_pkg::S_CREAD:    state_d = lcsm_pkg::S_CLATCH;
      lcsm_pkg::S_CLATCH:   state_d = lcsm_pkg::S_WALK;
      lcsm_pkg::S_WALK:     if (last_issue) state_d = lcsm_pkg::S_DRAIN;
      lcsm_pkg::S_DRAIN:    if (!v0_q && !v1_q) state_d = lcsm_pkg::S_MDIV;
      lcsm_pkg::S_MDIV:     state_d = lcsm_pkg::S_MWAIT;
      lcsm_pkg::S_MWAIT:    if (div_done) state_d = lcsm_pkg::S_STORE;
      lcsm_pkg::S_STORE:    state_d = pix_last ? lcsm_pkg::S_IDLE : lcsm_pkg::S_PIX_INIT;
      lcsm_pkg::S_RDIV:     state_d = (peak_q == '0) ? lcsm_pkg::S_EMIT : lcsm_pkg::S_RWAIT;
      lcsm_pkg::S_RWAIT:    if (div_done) state_d = lcsm_pkg::S_EMIT;
      lcsm_pkg::S_EMIT:     if (!m_valid_q || m_axis_tready) state_d = lcsm_pkg::S_IDLE;
      default:              state_d = lcsm_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = state_q == lcsm_pkg::S_IDLE;
    issue         = state_q == lcsm_pkg::S_WALK;
    div_start     = (state_q == lcsm_pkg::S_MDIV) ||
                    ((state_q == lcsm_pkg::S_RDIV) && (peak_q != '0));
    if (state_q == lcsm_pkg::S_MDIV) begin
      div_num = sum_q;
      div_den = cnt_q;
    end else begin
      div_num = {cdata_q, 8'd0} - {8'd0, cdata_q};
      div_den = {1'b0, peak_q};
    end
  end

  lcsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (s_fire && !s_axis_tuser) src_mem[load_pos_q] <= s_axis_tdata;
    data_q <= src_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lcsm_pkg::S_STORE) con_mem[pix_q] <= div_quot[7:0];
    cdata_q <= con_mem[read_pos_q];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcsm_pkg::S_IDLE;
      load_pos_q  <= '0;
      read_pos_q  <= '0;
      map_valid_q <= 1'b0;
      map_total_q <= '0;
      peak_q      <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      v0_q    <= issue;
      v1_q    <= v0_q;
      // The output register loads in EMIT and empties when taken.
      if ((state_q == lcsm_pkg::S_EMIT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        lcsm_pkg::S_IDLE: begin
          if (s_fire && !s_axis_tuser) begin
            if (load_trig) begin
              load_pos_q <= '0;
              peak_q     <= '0;
            end else begin
              load_pos_q <= lp_next[AW-1:0];
            end
          end else if (s_fire && read_ok) begin
            read_pos_q <= (rp_next == map_total_q) ? '0 : rp_next[AW-1:0];
          end
        end
        lcsm_pkg::S_STORE: begin
          if (div_quot[7:0] > peak_q) peak_q <= div_quot[7:0];
          if (pix_last) begin
            map_valid_q <= 1'b1;
            map_total_q <= cfg_i.total;
            read_pos_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q <= sum_q + {8'd0, diff};
      cnt_q <= cnt_q + 9'd1;
    end
    unique case (state_q)
      lcsm_pkg::S_IDLE: begin
        if (s_fire && !s_axis_tuser && load_trig) begin
          x_q   <= '0;
          y_q   <= '0;
          pix_q <= '0;
        end
        if (s_fire && s_axis_tuser) begin
          res_q  <= '0;
          last_q <= read_ok && (rp_next == map_total_q);
        end
      end
      lcsm_pkg::S_PIX_INIT: begin
        y0_q <= (y_q > CW'(cfg_i.radius)) ? (y_q - CW'(cfg_i.radius)) : '0;
        x0_q <= (x_q > CW'(cfg_i.radius)) ? (x_q - CW'(cfg_i.radius)) : '0;
        yl_q <= (yend < {1'b0, cfg_i.height}) ? CW'(yend - 1'b1) : CW'(cfg_i.height - 1'b1);
        xl_q <= (xend < {1'b0, cfg_i.width}) ? CW'(xend - 1'b1) : CW'(cfg_i.width - 1'b1);
      end
      lcsm_pkg::S_CADDR: addr_q <= pix_q;
      lcsm_pkg::S_CLATCH: begin
        centre_q <= data_q;
        wy_q     <= y0_q;
        wx_q     <= x0_q;
        sum_q    <= '0;
        cnt_q    <= '0;
      end
      lcsm_pkg::S_WALK: begin
        addr_q <= walk_prod[AW-1:0] + {{(AW-CW){1'b0}}, wx_q};
        if (wx_q == xl_q) begin
          wx_q <= x0_q;
          wy_q <= wy_q + 1'b1;
        end else begin
          wx_q <= wx_q + 1'b1;
        end
      end
      lcsm_pkg::S_STORE: begin
        pix_q <= pix_next[AW-1:0];
        if ({1'b0, x_q} == cfg_i.width - 1'b1) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      lcsm_pkg::S_RWAIT: if (div_done) res_q <= div_quot[7:0];
      lcsm_pkg::S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= res_q;
          m_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == lcsm_pkg::S_MWAIT || state_q == lcsm_pkg::S_RWAIT))
    else $error("divider result with nobody waiting");
  a_read_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_valid_q |-> ({1'b0, read_pos_q} < map_total_q && map_total_q != '0))
    else $error("read position outside the computed map");
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcsm_pkg::S_MDIV) |-> (!v0_q && !v1_q && cnt_q != '0))
    else $error("mean started with taps in flight or an empty window");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_local_contrast_saliency_map_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the local contrast saliency map.
// Several frames are loaded with many window radii and frame sizes, the
// extremes among them. Each saliency read is checked against a predictor
// that keeps its own copy of the frame, the contrast map and the settings.
module tb_local_contrast_saliency_map_top;

  typedef struct packed {
    logic [7:0] saliency;
    logic       last_pixel;
  } sal_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_addr_i;
  logic [8:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  local_contrast_saliency_map_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: raw register values plus the frame and map stores.
  logic [3:0]  radius_reg;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [7:0]  frame_mem [0:65535];
  logic [7:0]  contrast_mem [0:65535];
  int unsigned peak_contrast;
  int unsigned load_idx;
  int unsigned read_idx;
  bit          map_ready;
  int unsigned map_pixels;

  sal_item_t   saliency_q[$];
  bit          failed;
  int          items_sent;
  int          out_hold_cycles;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb_local_contrast_saliency_map_top: errors");
    $finish;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_w();
    return clip(width_reg, 1, lcsm_pkg::MaxWidth);
  endfunction

  function automatic int unsigned eff_h();
    return clip(height_reg, 1, lcsm_pkg::MaxHeight);
  endfunction

  // Mean absolute difference over the clipped window, then the peak.
  task automatic build_contrast_map();
    int unsigned w, h, r, y0, y1, x0, x1, ctr, p, sum, cnt, mean, pk;
    w = eff_w();
    h = eff_h();
    r = clip(radius_reg, 1, lcsm_pkg::MaxRadius);
    pk = 0;
    for (int unsigned y = 0; y < h; y++) begin
      y0 = (y > r) ? y - r : 0;
      y1 = (y + r < h) ? y + r : h;
      for (int unsigned x = 0; x < w; x++) begin
        x0 = (x > r) ? x - r : 0;
        x1 = (x + r < w) ? x + r : w;
        ctr = frame_mem[y * w + x];
        sum = 0;
        cnt = 0;
        for (int unsigned wy = y0; wy < y1; wy++) begin
          for (int unsigned wx = x0; wx < x1; wx++) begin
            p = frame_mem[wy * w + wx];
            sum += (p > ctr) ? p - ctr : ctr - p;
            cnt++;
          end
        end
        mean = (cnt != 0) ? sum / cnt : 0;
        if (mean > 255) mean = 255;
        contrast_mem[y * w + x] = mean[7:0];
        if (mean > pk) pk = mean;
      end
    end
    peak_contrast = pk;
    map_pixels = w * h;
    map_ready = 1'b1;
    read_idx = 0;
  endtask

  task automatic predict_saliency(logic mode, logic [7:0] pixel);
    sal_item_t   res;
    int unsigned s;
    if (mode == 1'b0) begin
      if (load_idx < 65536) frame_mem[load_idx] = pixel;
      load_idx++;
      if (load_idx >= eff_w() * eff_h()) begin
        build_contrast_map();
        load_idx = 0;
      end
    end else if (!map_ready || map_pixels == 0 || read_idx >= map_pixels) begin
      res = '0;
      saliency_q.push_back(res);
    end else begin
      s = (peak_contrast != 0) ?
          (contrast_mem[read_idx] * lcsm_pkg::FullScale) / peak_contrast : 0;
      if (s > 255) s = 255;
      res.saliency = s[7:0];
      res.last_pixel = (read_idx + 1 == map_pixels);
      saliency_q.push_back(res);
      read_idx++;
      if (read_idx >= map_pixels) read_idx = 0;
    end
  endtask

  // Mostly back-to-back, sometimes short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel_item(logic mode, logic [7:0] pixel);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pixel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_saliency(mode, pixel);
    items_sent++;
  endtask

  task automatic read_map(int n);
    for (int i = 0; i < n; i++) send_pixel_item(1'b1, 8'($urandom));
  endtask

  // Stop offering, let every read come back and any map build finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (saliency_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(lcsm_pkg::cfg_idx_e idx, logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      lcsm_pkg::CFG_RADIUS: radius_reg = data[3:0];
      lcsm_pkg::CFG_WIDTH:  width_reg  = data;
      lcsm_pkg::CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
  endtask

  task automatic set_frame(logic [8:0] r, logic [8:0] w, logic [8:0] h);
    settle();
    write_reg(lcsm_pkg::CFG_RADIUS, r);
    write_reg(lcsm_pkg::CFG_WIDTH, w);
    write_reg(lcsm_pkg::CFG_HEIGHT, h);
  endtask

  // The index outside the register list must leave every setting alone.
  task automatic write_unused_index();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= 2'd3;
    cfg_data_i  <= 9'($urandom);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_read_without_map();
    read_map(3);
  endtask

  task automatic test_tiny_frame();
    logic [7:0] pix [6] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd7};
    set_frame(9'd0, 9'd3, 9'd2);
    write_unused_index();
    foreach (pix[i]) send_pixel_item(1'b0, pix[i]);
    read_map(8);
  endtask

  // A flat frame has zero peak; a zero-size setting clamps to one pixel.
  task automatic test_flat_and_single();
    set_frame(9'd15, 9'd2, 9'd2);
    repeat (4) send_pixel_item(1'b0, 8'd255);
    read_map(4);
    set_frame(9'd1, 9'd0, 9'd0);
    send_pixel_item(1'b0, 8'd200);
    read_map(2);
  endtask

  task automatic test_wide_and_tall();
    set_frame(9'd8, 9'd511, 9'd1);
    repeat (256) send_pixel_item(1'b0, 8'($urandom));
    read_map(40);
    set_frame(9'd8, 9'd1, 9'd256);
    repeat (256) send_pixel_item(1'b0, 8'($urandom));
    read_map(30);
  endtask

  // Reads of the old map interleave with the loads of a new frame.
  task automatic test_reload_while_readable();
    set_frame(9'd2, 9'd4, 9'd3);
    for (int i = 0; i < 12; i++) begin
      send_pixel_item(1'b0, 8'($urandom));
      if (i % 3 == 0) send_pixel_item(1'b1, 8'($urandom));
    end
    read_map(6);
  endtask

  // Shrinking the frame after more pixels than the new size were loaded
  // makes the next load complete the frame.
  task automatic test_resize_mid_frame();
    set_frame(9'd3, 9'd5, 9'd4);
    repeat (10) send_pixel_item(1'b0, 8'($urandom));
    set_frame(9'd3, 9'd2, 9'd2);
    send_pixel_item(1'b0, 8'($urandom));
    read_map(5);
  endtask

  task automatic test_output_backpressure();
    quiet = 1'b1;
    out_hold_cycles = 400;
    read_map(30);
    quiet = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    read_map(5);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (saliency_q.size() != 0) @(posedge clk_i);
    read_map(5);
  endtask

  task automatic test_random_frames();
    logic [8:0] w, h;
    int         kind, npix;
    logic [7:0] flat, p;
    while (items_sent < 850) begin
      w = 9'($urandom_range(1, 8));
      h = 9'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) begin
        w = 9'($urandom_range(257, 511));
        h = 9'd1;
      end
      set_frame(9'($urandom), w, h);
      kind = $urandom_range(0, 9);
      flat = 8'($urandom);
      npix = eff_w() * eff_h();
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < npix; i++) begin
        if (kind == 0) p = flat;
        else if (kind == 1) p = ((i + i / eff_w()) % 2) ? 8'd255 : 8'd0;
        else p = 8'($urandom);
        send_pixel_item(1'b0, p);
        if ($urandom_range(0, 4) == 0) send_pixel_item(1'b1, 8'($urandom));
      end
      read_map($urandom_range(1, npix > 40 ? 40 : npix + 3));
      quiet = 1'b0;
    end
  endtask

  // Receiver: random backpressure, long holds on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_hold_cycles == 0 && !quiet && $urandom_range(0, 199) == 0)
        out_hold_cycles = $urandom_range(20, 60);
      if (out_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        out_hold_cycles--;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Every saliency transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    sal_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (saliency_q.size() == 0) begin
        $display("%0t: unexpected result saliency=%0d last=%0b",
                 $time, m_axis_tdata, m_axis_tlast);
        failed = 1'b1;
      end else begin
        want = saliency_q.pop_front();
        if (m_axis_tdata !== want.saliency) begin
          $display("%0t: saliency expected %0d actual %0d",
                   $time, want.saliency, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tlast !== want.last_pixel) begin
          $display("%0t: last_pixel expected %0b actual %0b",
                   $time, want.last_pixel, m_axis_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    radius_reg = 4'd5;
    width_reg = 9'd256;
    height_reg = 9'd256;
    peak_contrast = 0;
    load_idx = 0;
    read_idx = 0;
    map_ready = 1'b0;
    map_pixels = 0;
    failed = 1'b0;
    items_sent = 0;
    out_hold_cycles = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i <= lcsm_pkg::CFG_RADIUS;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_without_map();
    test_tiny_frame();
    test_flat_and_single();
    test_wide_and_tall();
    test_reload_while_readable();
    test_resize_mid_frame();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_frames();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (saliency_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("tb_local_contrast_saliency_map_top: clean");
    end else begin
      $display("tb_local_contrast_saliency_map_top: errors");
    end
    $finish;
  end

endmodule
